// ===== rtl/ssbr_pkg.sv =====
package ssbr_pkg;

    localparam int SET_IDX_W    = 11;
    localparam int WAY_IDX_W    = 5;
    localparam int ADDR_IN_W    = 48;
    localparam int RR_W         = 2;
    localparam int CONF_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 2;

    localparam int DEF_NUM_SETS  = 2048;
    localparam int DEF_NUM_WAYS  = 16;
    localparam int DEF_ADDR_BITS = 48;

    localparam logic [RR_W-1:0]   RR_MAX   = 2'd3;
    localparam logic [CONF_W-1:0] CONF_MAX = 2'd3;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 2'd2;
    localparam logic [CFG_DATA_W-1:0] INSERT_RST    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_INSERT_VALUE = 2'd1;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic                 done;
        logic [RR_W-1:0]      top;
        logic [WAY_IDX_W-1:0] way;
    } scan_stat_t;

    typedef struct packed {
        logic [CONF_W-1:0] conf;
        logic              streaming;
    } stride_res_t;

endpackage

// ===== rtl/ssbr_ram.sv =====
module ssbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssbr_scan.sv =====
module ssbr_scan #(
    parameter int NUM_WAYS = ssbr_pkg::DEF_NUM_WAYS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ssbr_pkg::RR_W*NUM_WAYS-1:0] row,
    output ssbr_pkg::scan_stat_t              stat
);

    import ssbr_pkg::*;

    localparam int WAY_W = $clog2(NUM_WAYS);

    logic             busy_reg;
    logic             done_reg;
    logic [WAY_W-1:0] cnt_reg;
    logic [RR_W-1:0]  top_reg;
    logic [WAY_W-1:0] idx_reg;
    logic [RR_W-1:0]  val;
    logic             last;

    assign val  = row[cnt_reg*RR_W +: RR_W];
    assign last = (cnt_reg == WAY_W'(NUM_WAYS - 1));

    // max search, first way holding the max wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= '0;
            top_reg <= '0;
            idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + WAY_W'(1);
            if (val > top_reg)
            begin
                top_reg <= val;
                idx_reg <= cnt_reg;
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.top  = top_reg;
    assign stat.way  = WAY_IDX_W'(idx_reg);

endmodule

// ===== rtl/ssbr_stride.sv =====
module ssbr_stride #(
    parameter int ADDR_BITS = ssbr_pkg::DEF_ADDR_BITS
) (
    input  logic [ADDR_BITS-1:0]             prev_addr,
    input  logic [ADDR_BITS:0]               prev_delta,
    input  logic [ssbr_pkg::CONF_W-1:0]      conf_in,
    input  logic [ADDR_BITS-1:0]             addr,
    input  logic [ssbr_pkg::CFG_DATA_W-1:0]  threshold,
    output logic [ADDR_BITS:0]               delta,
    output ssbr_pkg::stride_res_t            res
);

    import ssbr_pkg::*;

    logic              repeats;
    logic [CONF_W-1:0] conf;

    assign delta   = {1'b0, addr} - {1'b0, prev_addr};
    assign repeats = (prev_delta != '0) && (delta == prev_delta);

    always_comb
    begin
        conf = conf_in;
        if (repeats)
        begin
            if (conf_in != CONF_MAX)
            begin
                conf = conf_in + CONF_W'(1);
            end
        end
        else if (conf_in != '0)
        begin
            conf = conf_in - CONF_W'(1);
        end
    end

    assign res.conf      = conf;
    assign res.streaming = (conf >= threshold);

endmodule

// ===== rtl/srrip_stream_bypass_replacement.sv =====
// Update request: the row is read, then the result is registered.
// Victim query: the row is read, then the way scanner walks it, one way per cycle;
// a streaming set skips the scan, and a set at or above NUM_SETS skips the read too.
// One request at a time, the next taken the cycle after the result registers.
// Reset: control and config clear at once, then a clearing pass writes every set of
// both set memories; no request is taken until it ends.
module srrip_stream_bypass_replacement #(
    parameter int NUM_SETS  = ssbr_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS  = ssbr_pkg::DEF_NUM_WAYS,
    parameter int ADDR_BITS = ssbr_pkg::DEF_ADDR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              op,
    input  logic [ssbr_pkg::SET_IDX_W-1:0]    set_index,
    input  logic [ssbr_pkg::WAY_IDX_W-1:0]    way_index,
    input  logic [ssbr_pkg::ADDR_IN_W-1:0]    address,
    input  logic                              was_hit,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [ssbr_pkg::WAY_IDX_W-1:0]    victim_way,
    output logic                              bypass,
    output logic [ssbr_pkg::CONF_W-1:0]       confidence,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssbr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ssbr_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int IDX_W = (SET_W > SET_IDX_W) ? SET_W : SET_IDX_W;
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int AW    = ADDR_BITS;
    localparam int DW    = ADDR_BITS + 1;
    localparam int ROW_W = RR_W * NUM_WAYS;
    localparam int STR_W = AW + DW + CONF_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SET_W-1:0]      clr_cnt_reg;
    logic [CFG_DATA_W-1:0] thr_reg;
    logic [CFG_DATA_W-1:0] ins_reg;

    logic                  op_reg;
    logic [SET_W-1:0]      set_reg;
    logic [WAY_IDX_W-1:0]  way_reg;
    logic [AW-1:0]         addr_reg;
    logic                  hit_reg;
    logic [ROW_W-1:0]      rr_row_reg;

    logic [WAY_IDX_W-1:0]  res_victim_reg;
    logic                  res_bypass_reg;
    logic [CONF_W-1:0]     res_conf_reg;

    logic                  rsp_valid_reg;
    logic [WAY_IDX_W-1:0]  victim_way_reg;
    logic                  bypass_reg;
    logic [CONF_W-1:0]     confidence_reg;

    logic                  accept;
    logic                  in_range;
    logic                  way_ok;
    logic                  fin_load;
    logic [IDX_W-1:0]      set_ext;
    logic [SET_W-1:0]      raddr;

    logic                  rr_we;
    logic [SET_W-1:0]      rr_waddr;
    logic [ROW_W-1:0]      rr_wdata;
    logic [ROW_W-1:0]      rr_rdata;
    logic [ROW_W-1:0]      rr_upd_row;
    logic [ROW_W-1:0]      rr_aged_row;
    logic [ROW_W-1:0]      rr_rst_row;

    logic                  st_we;
    logic [SET_W-1:0]      st_waddr;
    logic [STR_W-1:0]      st_wdata;
    logic [STR_W-1:0]      st_rdata;
    logic [AW-1:0]         st_prev_addr;
    logic [DW-1:0]         st_prev_delta;
    logic [CONF_W-1:0]     st_conf;
    logic [DW-1:0]         new_delta;
    stride_res_t           str_res;

    logic                  scan_start;
    scan_stat_t            scan_stat;
    logic                  q_stream;
    logic [RR_W-1:0]       ins_val;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign set_ext   = IDX_W'(set_index);
    assign in_range  = (32'(set_index) < 32'(NUM_SETS));
    assign raddr     = (state_reg == ST_IDLE) ? set_ext[SET_W-1:0] : set_reg;
    assign way_ok    = (32'(way_reg) < 32'(NUM_WAYS));
    assign fin_load  = (state_reg == ST_FIN) && (!rsp_valid_reg || !rsp_stall);

    assign {st_prev_addr, st_prev_delta, st_conf} = st_rdata;
    assign q_stream  = (st_conf >= thr_reg);
    assign ins_val   = hit_reg ? RR_W'(0) : ins_reg;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rr_rst_row[w*RR_W +: RR_W]  = RR_MAX;
            rr_aged_row[w*RR_W +: RR_W] = RR_W'(rr_row_reg[w*RR_W +: RR_W]
                                               + (RR_MAX - scan_stat.top));
            if (WAY_W'(w) == way_reg[WAY_W-1:0])
            begin
                rr_upd_row[w*RR_W +: RR_W] = ins_val;
            end
            else
            begin
                rr_upd_row[w*RR_W +: RR_W] = rr_rdata[w*RR_W +: RR_W];
            end
        end
    end

    ssbr_stride #(
        .ADDR_BITS (ADDR_BITS)
    ) u_stride (
        .prev_addr  (st_prev_addr),
        .prev_delta (st_prev_delta),
        .conf_in    (st_conf),
        .addr       (addr_reg),
        .threshold  (thr_reg),
        .delta      (new_delta),
        .res        (str_res)
    );

    ssbr_scan #(
        .NUM_WAYS (NUM_WAYS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .row   (rr_row_reg),
        .stat  (scan_stat)
    );

    ssbr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rr_ram (
        .clk   (clk),
        .we    (rr_we),
        .waddr (rr_waddr),
        .wdata (rr_wdata),
        .raddr (raddr),
        .rdata (rr_rdata)
    );

    ssbr_ram #(
        .WIDTH (STR_W),
        .DEPTH (NUM_SETS)
    ) u_str_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        rr_we      = 1'b0;
        rr_waddr   = set_reg;
        rr_wdata   = rr_upd_row;
        st_we      = 1'b0;
        st_waddr   = set_reg;
        st_wdata   = {addr_reg, new_delta, str_res.conf};
        scan_start = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                rr_we    = 1'b1;
                rr_waddr = clr_cnt_reg;
                rr_wdata = rr_rst_row;
                st_we    = 1'b1;
                st_waddr = clr_cnt_reg;
                st_wdata = '0;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_READ : ST_FIN;
                end
            end
            ST_READ:
            begin
                if (op_reg == OP_UPDATE)
                begin
                    st_we      = 1'b1;
                    rr_we      = way_ok && (hit_reg || !str_res.streaming);
                    state_next = ST_FIN;
                end
                else if (q_stream)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    rr_we      = 1'b1;
                    rr_wdata   = rr_aged_row;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            thr_reg       <= THRESHOLD_RST;
            ins_reg       <= INSERT_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BYPASS_THRESHOLD:  thr_reg <= cfg_data;
                    CFG_MISS_INSERT_VALUE: ins_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (fin_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= op;
            set_reg        <= set_ext[SET_W-1:0];
            way_reg        <= way_index;
            addr_reg       <= AW'(address);
            hit_reg        <= was_hit;
            res_victim_reg <= '0;
            res_bypass_reg <= 1'b0;
            res_conf_reg   <= '0;
        end
        if (state_reg == ST_READ)
        begin
            if (op_reg == OP_UPDATE)
            begin
                res_bypass_reg <= str_res.streaming;
                res_conf_reg   <= str_res.conf;
            end
            else
            begin
                rr_row_reg     <= rr_rdata;
                res_bypass_reg <= q_stream;
                res_conf_reg   <= st_conf;
                if (q_stream)
                begin
                    res_victim_reg <= WAY_IDX_W'(NUM_WAYS);
                end
            end
        end
        if ((state_reg == ST_SCAN) && scan_stat.done)
        begin
            res_victim_reg <= scan_stat.way;
        end
        if (fin_load)
        begin
            victim_way_reg <= res_victim_reg;
            bypass_reg     <= res_bypass_reg;
            confidence_reg <= res_conf_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign victim_way = victim_way_reg;
    assign bypass     = bypass_reg;
    assign confidence = confidence_reg;

endmodule

// ===== rtl/ssbr_checker.sv =====
module ssbr_checker #(
    parameter int NUM_WAYS = ssbr_pkg::DEF_NUM_WAYS
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input logic [ssbr_pkg::WAY_IDX_W-1:0] victim_way,
    input logic                           bypass,
    input logic [ssbr_pkg::CONF_W-1:0]    confidence,
    input logic                           cfg_ready
);

    import ssbr_pkg::*;

    // one request in flight at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // a bypassed result names way zero or the out-of-range code NUM_WAYS
    a_bypass_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bypass |->
            (victim_way == '0) || (victim_way == WAY_IDX_W'(NUM_WAYS)))
        else $error("bypass with real victim way");

    // a fresh result only follows a busy cycle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(victim_way)
            && $stable(bypass) && $stable(confidence))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && !rsp_valid |=> cfg_ready)
        else $error("config port dropped ready");

endmodule

bind srrip_stream_bypass_replacement ssbr_checker #(
    .NUM_WAYS (NUM_WAYS)
) u_ssbr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .victim_way (victim_way),
    .bypass     (bypass),
    .confidence (confidence),
    .cfg_ready  (cfg_ready)
);
